// ===== sv/mco_pkg.sv =====
package mco_pkg;

    localparam int MAX_MATRICES = 8;
    localparam int DIM_WIDTH    = 16;

    localparam int COST_W     = 52;
    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};
    localparam int IDX_W      = (MAX_MATRICES > 2) ? $clog2(MAX_MATRICES) : 1;
    localparam int DADDR_W    = $clog2(MAX_MATRICES + 1);
    localparam int CNT_W      = $clog2(MAX_MATRICES + 3);
    localparam int COST_DEPTH = 1 << (2 * IDX_W);
    localparam int PAB_W      = 2 * DIM_WIDTH;
    localparam int PROD_W     = 3 * DIM_WIDTH;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_SHORT = 2'd1;
    localparam logic [1:0] STAT_LONG  = 2'd2;

    typedef enum logic [2:0] {
        S_LOAD,
        S_SUB_RD,
        S_SUB_MUL,
        S_SPL_RD,
        S_SPL_MUL,
        S_SPL_CMP,
        S_WR,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic start;
        logic sub_rd;
        logic sub_mul;
        logic spl_rd;
        logic spl_mul;
        logic spl_cmp;
        logic wr;
        logic next_sub;
    } t_cmd;

    typedef struct packed {
        logic short_chain;
        logic long_chain;
        logic single;
        logic split_last;
        logic out_last;
    } t_sts;

endpackage

// ===== sv/mco_dp.sv =====
module mco_dp
    import mco_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [15:0] i_dim,
    input  logic        i_last_dim,
    output logic [3:0]  o_first_matrix,
    output logic [3:0]  o_final_matrix,
    output logic [51:0] o_min_mults,
    output logic [2:0]  o_best_split,
    output logic [1:0]  o_status,
    output logic        o_last_result
);

    localparam int MX_W  = IDX_W + 1;
    localparam int EXT_W = (PROD_W > COST_W) ? PROD_W : COST_W;

    logic [DIM_WIDTH-1:0] r_dim_mem [0:MAX_MATRICES];
    logic [COST_W-1:0]    r_cost_mem [0:COST_DEPTH-1];

    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     n_cnt;
    logic [IDX_W-1:0]     r_nml;
    logic [IDX_W-1:0]     r_len;
    logic [IDX_W-1:0]     r_lo;
    logic [IDX_W-1:0]     r_s;
    logic [IDX_W-1:0]     r_bs;
    logic [IDX_W-1:0]     w_hi;
    logic [IDX_W-1:0]     w_s_inc;
    logic [DADDR_W-1:0]   w_addr_a;
    logic [DADDR_W-1:0]   w_addr_b;
    logic [DIM_WIDTH-1:0] r_dim_a;
    logic [DIM_WIDTH-1:0] r_dim_b;
    logic [PAB_W-1:0]     r_pab;
    logic [PAB_W-1:0]     w_pab;
    logic [PROD_W-1:0]    r_prod;
    logic [PROD_W-1:0]    w_prod;
    logic [EXT_W-1:0]     w_prod_x;
    logic [COST_W-1:0]    w_prod_sat;
    logic [COST_W-1:0]    r_c1;
    logic [COST_W-1:0]    r_c2;
    logic                 r_diag1;
    logic                 r_diag2;
    logic [COST_W-1:0]    w_c1;
    logic [COST_W-1:0]    w_c2;
    logic [COST_W:0]      w_sum_a;
    logic [COST_W-1:0]    w_sum;
    logic [COST_W-1:0]    r_sum;
    logic [COST_W:0]      w_cand_a;
    logic [COST_W-1:0]    w_cand;
    logic [COST_W-1:0]    r_best;
    logic [MX_W-1:0]      w_first;
    logic [MX_W-1:0]      w_final;
    logic [MX_W-1:0]      w_split;

    logic [3:0]           r_first;
    logic [3:0]           r_final;
    logic [COST_W-1:0]    r_mults;
    logic [2:0]           r_split;
    logic [1:0]           r_status;
    logic                 r_last;

    assign n_cnt = (r_cnt < CNT_W'(MAX_MATRICES + 1)) ? r_cnt + CNT_W'(1)
                                                      : CNT_W'(MAX_MATRICES + 2);
    assign w_hi    = r_lo + r_len;
    assign w_s_inc = r_s + IDX_W'(1);

    assign w_addr_a = i_cmd.sub_rd ? DADDR_W'(r_lo) : DADDR_W'(r_s) + DADDR_W'(1);
    assign w_addr_b = DADDR_W'(w_hi) + DADDR_W'(1);

    assign w_pab  = PAB_W'(r_dim_a) * PAB_W'(r_dim_b);
    assign w_prod = PROD_W'(r_pab) * PROD_W'(r_dim_a);

    assign w_c1    = r_diag1 ? '0 : r_c1;
    assign w_c2    = r_diag2 ? '0 : r_c2;
    assign w_sum_a = {1'b0, w_c1} + {1'b0, w_c2};
    assign w_sum   = w_sum_a[COST_W] ? COST_MAX : w_sum_a[COST_W-1:0];

    assign w_prod_x   = EXT_W'(r_prod);
    assign w_prod_sat = (w_prod_x > EXT_W'(COST_MAX)) ? COST_MAX : COST_W'(w_prod_x);
    assign w_cand_a   = {1'b0, r_sum} + {1'b0, w_prod_sat};
    assign w_cand     = w_cand_a[COST_W] ? COST_MAX : w_cand_a[COST_W-1:0];

    assign w_first = MX_W'(r_lo) + MX_W'(1);
    assign w_final = MX_W'(w_hi) + MX_W'(1);
    assign w_split = MX_W'(r_bs) + MX_W'(1);

    always_comb begin
        o_sts.short_chain = n_cnt < CNT_W'(2);
        o_sts.long_chain  = n_cnt > CNT_W'(MAX_MATRICES + 1);
        o_sts.single      = n_cnt == CNT_W'(2);
        o_sts.split_last  = w_s_inc == w_hi;
        o_sts.out_last    = r_last;
    end

    // dimension store
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && r_cnt < CNT_W'(MAX_MATRICES + 1)) begin
            r_dim_mem[r_cnt[DADDR_W-1:0]] <= DIM_WIDTH'(i_dim);
        end
        if (i_cmd.sub_rd || i_cmd.spl_rd) begin
            r_dim_a <= r_dim_mem[w_addr_a];
        end
        if (i_cmd.sub_rd) begin
            r_dim_b <= r_dim_mem[w_addr_b];
        end
    end

    // cost table
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_cost_mem[{r_lo, w_hi}] <= r_best;
        end
        if (i_cmd.spl_rd) begin
            r_c1 <= r_cost_mem[{r_lo, r_s}];
            r_c2 <= r_cost_mem[{w_s_inc, w_hi}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= i_last_dim ? '0 : n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_len <= IDX_W'(1);
            r_lo  <= '0;
            r_nml <= IDX_W'(n_cnt - CNT_W'(2));
        end
        if (i_cmd.next_sub) begin
            if (w_hi < r_nml) begin
                r_lo <= r_lo + IDX_W'(1);
            end else begin
                r_lo  <= '0;
                r_len <= r_len + IDX_W'(1);
            end
        end
        if (i_cmd.sub_mul) begin
            r_pab  <= w_pab;
            r_best <= COST_MAX;
            r_bs   <= r_lo;
            r_s    <= r_lo;
        end
        if (i_cmd.spl_rd) begin
            r_diag1 <= r_s == r_lo;
            r_diag2 <= w_s_inc == w_hi;
        end
        if (i_cmd.spl_mul) begin
            r_prod <= w_prod;
            r_sum  <= w_sum;
        end
        if (i_cmd.spl_cmp) begin
            if (w_cand < r_best) begin
                r_best <= w_cand;
                r_bs   <= r_s;
            end
            r_s <= w_s_inc;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mults <= '0;
            r_split <= '0;
            r_last  <= 1'b1;
            if (o_sts.single) begin
                r_first <= 4'd1;
                r_final <= 4'd1;
            end else begin
                r_first <= '0;
                r_final <= '0;
            end
            if (o_sts.short_chain) begin
                r_status <= STAT_SHORT;
            end else if (o_sts.long_chain) begin
                r_status <= STAT_LONG;
            end else begin
                r_status <= STAT_OK;
            end
        end
        if (i_cmd.wr) begin
            r_first  <= 4'(w_first);
            r_final  <= 4'(w_final);
            r_mults  <= r_best;
            r_split  <= 3'(w_split);
            r_status <= STAT_OK;
            r_last   <= r_len == r_nml;
        end
    end

    assign o_first_matrix = r_first;
    assign o_final_matrix = r_final;
    assign o_min_mults    = r_mults;
    assign o_best_split   = r_split;
    assign o_status       = r_status;
    assign o_last_result  = r_last;

endmodule

// ===== sv/mco_ctrl.sv =====
module mco_ctrl
    import mco_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_last_dim,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (i_valid && i_last_dim) begin
                    if (i_sts.short_chain || i_sts.long_chain || i_sts.single) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_SUB_RD;
                    end
                end
            end
            S_SUB_RD:  n_state = S_SUB_MUL;
            S_SUB_MUL: n_state = S_SPL_RD;
            S_SPL_RD:  n_state = S_SPL_MUL;
            S_SPL_MUL: n_state = S_SPL_CMP;
            S_SPL_CMP: n_state = i_sts.split_last ? S_WR : S_SPL_RD;
            S_WR:      n_state = S_OUT;
            S_OUT: begin
                if (!i_stall) begin
                    n_state = i_sts.out_last ? S_LOAD : S_SUB_RD;
                end
            end
            default:   n_state = S_LOAD;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_stall     = 1'b0;
                o_cmd.load  = i_valid;
                o_cmd.start = i_valid && i_last_dim;
            end
            S_SUB_RD:  o_cmd.sub_rd  = 1'b1;
            S_SUB_MUL: o_cmd.sub_mul = 1'b1;
            S_SPL_RD:  o_cmd.spl_rd  = 1'b1;
            S_SPL_MUL: o_cmd.spl_mul = 1'b1;
            S_SPL_CMP: o_cmd.spl_cmp = 1'b1;
            S_WR:      o_cmd.wr      = 1'b1;
            S_OUT: begin
                o_valid        = 1'b1;
                o_cmd.next_sub = !i_stall && !i_sts.out_last;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== sv/matrix_chain_order_dp.sv =====
// dimensions load at one per cycle; stall is high from the flagged dimension until
// the final result transaction completes
// a subchain first fetches its outer dimensions, then reads, multiplies and compares
// each split, then writes and offers its result; the next starts once a result is taken
// error and single-matrix chains give their result the cycle after the flagged item
// reset clears the controller and dimension count; the tables need no clearing pass
module matrix_chain_order_dp
    import mco_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_dim,
    input  logic        i_last_dim,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_first_matrix,
    output logic [3:0]  o_final_matrix,
    output logic [51:0] o_min_mults,
    output logic [2:0]  o_best_split,
    output logic [1:0]  o_status,
    output logic        o_last_result
);

    t_cmd w_cmd;
    t_sts w_sts;

    mco_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_last_dim (i_last_dim),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mco_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_dim          (i_dim),
        .i_last_dim     (i_last_dim),
        .o_first_matrix (o_first_matrix),
        .o_final_matrix (o_final_matrix),
        .o_min_mults    (o_min_mults),
        .o_best_split   (o_best_split),
        .o_status       (o_status),
        .o_last_result  (o_last_result)
    );

endmodule
